FILE: sv/fdfq_pkg.sv
// Shared types and constants for the float to dynamic fixed-point quantizer.
package fdfq_pkg;
   localparam int CODE_WIDTH      = 24;
   localparam int BW_WIDTH        = 5;
   localparam int FL_WIDTH        = 7;
   localparam int CSR_DATA_WIDTH  = 7;
   localparam int CSR_INDEX_WIDTH = 1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CODE_BITS   = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FRAC_LENGTH = 1'b1;
   localparam logic [BW_WIDTH-1:0] BW_RESET = 5'd8;
   localparam logic [FL_WIDTH-1:0] FL_RESET = 7'd0;

   // Decoded operand after stage 1.
   typedef struct packed {
      logic        neg;
      logic        inval;
      logic        inf;
      logic        zero;
      logic [23:0] mant;
      logic signed [9:0] shift;   // exponent - 150 + frac_length
      logic [24:0] limit;         // magnitude bound for this sign
      logic        last;
   } dec_type;

   // Aligned magnitude after stage 2.
   typedef struct packed {
      logic        neg;
      logic        inval;
      logic        sat;
      logic [24:0] q;
      logic        guard;
      logic        sticky;
      logic [24:0] limit;
      logic        last;
   } aln_type;
endpackage

FILE: sv/fdfq_align.sv
// Stage 2: shift the significand into place and collect round bits.
module fdfq_align import fdfq_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    valid_in,
   input  dec_type dec_in,
   output logic    valid_out,
   output aln_type aln_out
);
   logic    valid_ff;
   aln_type aln_ff, aln_in;
   logic [47:0] wide;
   logic [23:0] low;
   logic [5:0]  r;

   always_comb begin
      aln_in        = '0;
      aln_in.neg    = dec_in.neg;
      aln_in.inval  = dec_in.inval;
      aln_in.limit  = dec_in.limit;
      aln_in.last   = dec_in.last;
      wide          = '0;
      low           = '0;
      r             = '0;
      if (dec_in.inval || dec_in.zero) begin
         aln_in.q = '0;
      end else if (dec_in.inf) begin
         aln_in.sat = 1'b1;
      end else if (dec_in.shift >= 0) begin
         if (dec_in.shift >= 10'sd24) begin
            aln_in.sat = 1'b1;
         end else begin
            wide = {24'd0, dec_in.mant} << dec_in.shift[4:0];
            aln_in.q = wide[24:0];
            if (wide[47:25] != '0) aln_in.sat = 1'b1;
         end
      end else if (-dec_in.shift > 10'sd25) begin
         aln_in.sticky = 1'b1;   // mant nonzero, below half
      end else begin
         r = 6'(-dec_in.shift);
         wide = {dec_in.mant, 24'd0} >> r;
         aln_in.q      = {1'b0, wide[47:24]};
         aln_in.guard  = wide[23];
         low           = {1'b0, wide[22:0]};
         aln_in.sticky = (low != '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else       valid_ff <= valid_in;
      aln_ff <= aln_in;
   end

   assign valid_out = valid_ff;
   assign aln_out   = aln_ff;
endmodule

FILE: sv/fdfq_round.sv
// Stage 3: clamp, round to nearest even and apply the sign.
module fdfq_round import fdfq_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  valid_in,
   input  aln_type               aln_in,
   output logic                  valid_out,
   output logic [CODE_WIDTH-1:0] code,
   output logic                  saturated,
   output logic                  invalid,
   output logic                  last_out
);
   logic                  valid_ff, sat_ff, inval_ff, last_ff;
   logic [CODE_WIDTH-1:0] code_ff, code_in;
   logic                  sat_in, up;
   logic [24:0]           mag;

   always_comb begin
      sat_in = aln_in.sat;
      up     = aln_in.guard && (aln_in.sticky || aln_in.q[0]);
      mag    = aln_in.q + 25'(up);
      if (aln_in.q > aln_in.limit ||
          (aln_in.q == aln_in.limit && (aln_in.guard || aln_in.sticky)))
         sat_in = 1'b1;
      if (sat_in) mag = aln_in.limit;
      if (aln_in.inval) mag = '0;
      code_in = aln_in.neg ? CODE_WIDTH'(-mag) : mag[CODE_WIDTH-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else       valid_ff <= valid_in;
      code_ff  <= code_in;
      sat_ff   <= sat_in && !aln_in.inval;
      inval_ff <= aln_in.inval;
      last_ff  <= aln_in.last;
   end

   assign valid_out = valid_ff;
   assign code      = code_ff;
   assign saturated = sat_ff;
   assign invalid   = inval_ff;
   assign last_out  = last_ff;
endmodule

FILE: sv/float_to_dynamic_fixed_quantizer_core.sv
// Top level of the float to dynamic fixed-point quantizer.
//
//  channel  | handshake          | payload
//  request  | start / busy       | req_value_bits, req_last
//  result   | rsp_valid (strobe) | rsp_code, rsp_saturated, rsp_invalid, rsp_last_out
//  config   | csr_write_enable   | csr_index, csr_write_data
//
// One request per cycle; once a request is taken, its result goes through the decode, align
// and round/clamp registers. busy is always low: the pipeline never
// stalls and the receiver cannot hold results off.
// Synchronous active-high reset clears valid bits and restores a code width of 8,
// frac_length 0.
module float_to_dynamic_fixed_quantizer_core import fdfq_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [31:0]                req_value_bits,
   input  logic                       req_last,
   output logic                       rsp_valid,
   output logic signed [CODE_WIDTH-1:0] rsp_code,
   output logic                       rsp_saturated,
   output logic                       rsp_invalid,
   output logic                       rsp_last_out,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_write_data
);
   logic [BW_WIDTH-1:0] bw_ff;
   logic [FL_WIDTH-1:0] fl_ff;
   logic                v1_ff, v2;
   dec_type             dec_ff, dec_in;
   aln_type             aln;
   logic [CODE_WIDTH-1:0] code_raw;
   logic [4:0]          bw_eff;
   logic signed [6:0]   fl_eff;
   logic [7:0]          ex;
   logic [24:0]         half_range;

   assign busy = 1'b0;

   // Register file.
   always_ff @(posedge clock) begin
      if (reset) begin
         bw_ff <= BW_RESET;
         fl_ff <= FL_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_CODE_BITS:   bw_ff <= csr_write_data[BW_WIDTH-1:0];
            CSR_FRAC_LENGTH: fl_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // Stage 1: decode fields and clamp the register values.
   always_comb begin
      bw_eff = (bw_ff < 5'd2) ? 5'd2 : (bw_ff > 5'd24) ? 5'd24 : bw_ff;
      fl_eff = $signed(fl_ff);
      if (fl_eff < -7'sd32) fl_eff = -7'sd32;
      if (fl_eff > 7'sd32)  fl_eff = 7'sd32;
      ex           = req_value_bits[30:23];
      half_range   = 25'd1 << (bw_eff - 5'd1);
      dec_in.neg   = req_value_bits[31];
      dec_in.inval = (ex == 8'hFF) && (req_value_bits[22:0] != '0);
      dec_in.inf   = (ex == 8'hFF) && (req_value_bits[22:0] == '0);
      dec_in.mant  = {(ex != 8'd0), req_value_bits[22:0]};
      dec_in.zero  = (dec_in.mant == '0);
      dec_in.shift = $signed({2'b00, (ex == 8'd0) ? 8'd1 : ex}) - 10'sd150
                     + 10'(fl_eff);
      dec_in.limit = req_value_bits[31] ? half_range : half_range - 25'd1;
      dec_in.last  = req_last;
   end

   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else       v1_ff <= start;
      dec_ff <= dec_in;
   end

   fdfq_align u_align (
      .clock, .reset, .valid_in(v1_ff), .dec_in(dec_ff), .valid_out(v2), .aln_out(aln)
   );

   fdfq_round u_round (
      .clock, .reset, .valid_in(v2), .aln_in(aln), .valid_out(rsp_valid),
      .code(code_raw), .saturated(rsp_saturated), .invalid(rsp_invalid),
      .last_out(rsp_last_out)
   );

   assign rsp_code = $signed(code_raw);
endmodule

FILE: sv/fdfq_checker.sv
// Port-level checks for the quantizer core, bound to the top level.
module fdfq_checker import fdfq_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  start,
   input logic                  busy,
   input logic                  rsp_valid,
   input logic [CODE_WIDTH-1:0] rsp_code,
   input logic                  rsp_saturated,
   input logic                  rsp_invalid
);
   a_latency: assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> ##3 rsp_valid) else $error("result missing");
   a_nan_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_invalid |-> rsp_code == '0 && !rsp_saturated)
      else $error("invalid result not zero");
   a_no_stall: assert property (@(posedge clock) !busy) else $error("busy");
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, 3)) else $error("result without request");
endmodule

bind float_to_dynamic_fixed_quantizer_core fdfq_checker u_fdfq_checker (
   .clock, .reset, .start, .busy, .rsp_valid, .rsp_code, .rsp_saturated, .rsp_invalid
);

FILE: tb/tb.sv
// Self-checking testbench for the float to dynamic fixed-point quantizer core.
`timescale 1ns / 100ps
module tb;
   import fdfq_pkg::*;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          start = 1'b0;
   logic                          busy;
   logic [31:0]                   req_value_bits = '0;
   logic                          req_last = 1'b0;
   logic                          rsp_valid;
   logic signed [CODE_WIDTH-1:0]  rsp_code;
   logic                          rsp_saturated;
   logic                          rsp_invalid;
   logic                          rsp_last_out;
   logic                          csr_write_enable = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0]    csr_index = CSR_CODE_BITS;
   logic [CSR_DATA_WIDTH-1:0]     csr_write_data = '0;

   // Result fields as the quantizer should produce them.
   typedef struct packed {
      logic [CODE_WIDTH-1:0] code;
      logic                  sat;
      logic                  inval;
      logic                  last;
   } quant_result_t;

   localparam int PIPE_LATENCY = 3;
   localparam int STALL_LIMIT  = 2000;

   quant_result_t pending_codes[$];
   logic [BW_WIDTH-1:0] cur_code_bits = BW_RESET;
   logic [FL_WIDTH-1:0] cur_frac_length = FL_RESET;
   int mismatch_count = 0;
   int request_count = 0;
   int result_count = 0;
   int nan_count = 0;
   int idle_cycles = 0;

   float_to_dynamic_fixed_quantizer_core uut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Exact quantization: decode, align by exponent + frac_length, round half even, clamp.
   function automatic quant_result_t quantize(input logic [31:0] bits, input logic last_in);
      quant_result_t res;
      int bw, fl, sh, r;
      logic neg;
      logic [7:0] ex;
      logic [63:0] m, mag, lim, q, rem, half;
      bw = int'(cur_code_bits);
      if (bw < 2) bw = 2;
      if (bw > 24) bw = 24;
      fl = int'($signed(cur_frac_length));
      if (fl < -32) fl = -32;
      if (fl > 32) fl = 32;
      neg = bits[31];
      ex = bits[30:23];
      lim = (64'd1 << (bw - 1)) - (neg ? 64'd0 : 64'd1);
      res = '0;
      res.last = last_in;
      mag = 0;
      if (ex == 8'hFF) begin
         if (bits[22:0] != 0) res.inval = 1'b1;
         else begin
            res.sat = 1'b1;
            mag = lim;
         end
      end else begin
         m = (ex == 0) ? {41'd0, bits[22:0]} : {40'd0, 1'b1, bits[22:0]};
         sh = ((ex == 0) ? 1 : int'(ex)) - 150 + fl;
         if (m == 0) mag = 0;
         else if (sh >= 0) begin
            if (sh >= 24) res.sat = 1'b1;
            else begin
               mag = m << sh;
               if (mag > lim) res.sat = 1'b1;
            end
            if (res.sat) mag = lim;
         end else begin
            r = -sh;
            if (r >= 40) begin
               q = 0;
               rem = m;
               half = 64'd1 << 39;
            end else begin
               q = m >> r;
               rem = m & ((64'd1 << r) - 1);
               half = 64'd1 << (r - 1);
            end
            if (q > lim || (q == lim && rem != 0)) begin
               res.sat = 1'b1;
               mag = lim;
            end else begin
               mag = q;
               if (rem > half || (rem == half && q[0])) mag = q + 1;
            end
         end
      end
      res.code = neg ? (24'd0 - mag[23:0]) : mag[23:0];
      return res;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("MISMATCH result %0d: %s got %0h expected %0h", result_count, what, got, want);
      mismatch_count++;
   endtask

   // Result checker: the strobe is sampled at the edge that ends its cycle.
   always @(posedge clock) begin
      quant_result_t want;
      if (!reset && rsp_valid) begin
         if (pending_codes.size() == 0) begin
            $display("MISMATCH: result with nothing outstanding");
            mismatch_count++;
         end else begin
            want = pending_codes.pop_front();
            if (rsp_code !== want.code) report_mismatch("code", rsp_code, want.code);
            if (rsp_saturated !== want.sat) report_mismatch("saturated", rsp_saturated, want.sat);
            if (rsp_invalid !== want.inval) report_mismatch("invalid", rsp_invalid, want.inval);
            if (rsp_last_out !== want.last) report_mismatch("last_out", rsp_last_out, want.last);
         end
         result_count++;
      end
   end

   // Watchdog on cycles without any request or result taken.
   always @(posedge clock) begin
      if (!reset) begin
         if ((start && !busy) || rsp_valid) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog expired");
            $display("tb failed");
            $finish;
         end
      end
   end

   // Send one request after an optional random gap; the prediction is queued at acceptance.
   task automatic send_request(input logic [31:0] bits, input logic last_in, input bit gaps = 1);
      int gap;
      gap = gaps ? $urandom_range(0, 11) : 0;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_value_bits <= bits;
      req_last <= last_in;
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_codes.push_back(quantize(bits, last_in));
      request_count++;
      if (bits[30:23] == 8'hFF && bits[22:0] != 0) nan_count++;
   endtask

   // Drain the pipe, then write a register while the block is idle.
   task automatic write_csr(input logic [CSR_INDEX_WIDTH-1:0] idx,
                            input logic [CSR_DATA_WIDTH-1:0] data);
      start <= 1'b0;
      @(posedge clock);
      while (pending_codes.size() != 0) @(posedge clock);
      repeat (PIPE_LATENCY) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (idx == CSR_CODE_BITS) cur_code_bits = data[BW_WIDTH-1:0];
      else cur_frac_length = data;
   endtask

   task automatic set_format(input int bw, input int fl);
      write_csr(CSR_CODE_BITS, CSR_DATA_WIDTH'(bw));
      write_csr(CSR_FRAC_LENGTH, CSR_DATA_WIDTH'(fl));
   endtask

   // Random float biased toward exponents near the current scaling.
   function automatic logic [31:0] random_float();
      logic [31:0] v;
      int fl;
      v = $urandom;
      fl = int'($signed(cur_frac_length));
      case ($urandom_range(0, 9))
         0, 1: ;
         2: v[30:23] = 8'($urandom_range(0, 3));
         3: v[30:23] = 8'hFF;
         default: v[30:23] = 8'(127 - fl + $urandom_range(0, 30) - 5);
      endcase
      return v;
   endfunction

   // Directed: zeros, subnormals, infinities, NaNs, ties and the range bounds.
   task automatic test_special_values();
      logic [31:0] vals[$];
      vals = '{32'h0000_0000, 32'h8000_0000, 32'h0000_0001, 32'h807F_FFFF,
               32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0000, 32'hFF80_0001,
               32'h3F00_0000, 32'h3FC0_0000, 32'h4020_0000, 32'hBF00_0000,
               32'hBFC0_0000, 32'h42FE_0000, 32'h42FF_0000, 32'hC300_0000,
               32'hC301_0000, 32'h7F7F_FFFF, 32'hFFFF_FFFF, 32'h3EFF_FFFF};
      set_format(8, 0);
      foreach (vals[i]) send_request(vals[i], 1'(i % 2), 0);
      set_format(24, 0);
      send_request(32'h4AFF_FFFE, 1'b0);
      send_request(32'hCB00_0000, 1'b1);
      send_request(32'hCB00_0001, 1'b0);
   endtask

   // Register extremes, including codes outside the meaningful ranges.
   task automatic test_format_extremes();
      int bws[] = '{0, 1, 2, 24, 31, 13};
      int fls[] = '{-64, -32, 32, 63, -1, 5};
      foreach (bws[i]) begin
         set_format(bws[i], fls[i]);
         repeat (12) send_request(random_float(), 1'($urandom_range(0, 1)));
      end
   endtask

   // Random formats and values; some bursts with no gaps at all.
   task automatic test_random_stream();
      for (int phase = 0; phase < 12; phase++) begin
         set_format($urandom_range(0, 31), $urandom_range(0, 127));
         repeat (30) send_request(random_float(), 1'($urandom_range(0, 1)), phase % 3 != 0);
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_request(32'h4040_0000, 1'b0); // reset format: 8 bits, no fraction
      test_special_values();
      test_format_extremes();
      test_random_stream();
      start <= 1'b0;
      @(posedge clock);
      while (pending_codes.size() != 0) @(posedge clock);
      repeat (PIPE_LATENCY + 2) @(posedge clock);
      $display("Covered %0d requests over 20 formats, %0d results, %0d NaN inputs.",
               request_count, result_count, nan_count);
      if (mismatch_count == 0 && pending_codes.size() == 0) $display("tb passed");
      else $display("tb failed");
      $finish;
   end
endmodule

FILE: float_to_dynamic_fixed_quantizer_core.f
sv/fdfq_pkg.sv
sv/fdfq_align.sv
sv/fdfq_round.sv
sv/float_to_dynamic_fixed_quantizer_core.sv
sv/fdfq_checker.sv
tb/tb.sv
